// ----- src/vfq_pkg.sv -----
// Package with the request and response types and the codes of the video frame queue.
package vfq_pkg;

   localparam int HANDLE_BITS = 16;
   localparam int ENTRY_BITS  = HANDLE_BITS + 1;
   localparam int CFG_BITS    = 7;
   localparam int COUNT_BITS  = 7;

   localparam logic [2:0] FUNC_PUSH    = 3'd0;
   localparam logic [2:0] FUNC_POP     = 3'd1;
   localparam logic [2:0] FUNC_CLEAR   = 3'd2;
   localparam logic [2:0] FUNC_CUT_OLD = 3'd3;
   localparam logic [2:0] FUNC_CUT_P   = 3'd4;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   localparam logic [1:0] CSR_I_FRAME_LIMIT     = 2'd0;
   localparam logic [1:0] CSR_SECONDS_LIMIT     = 2'd1;
   localparam logic [1:0] CSR_FRAMES_PER_SECOND = 2'd2;

   typedef struct packed {
      logic [2:0]             func;
      logic [HANDLE_BITS-1:0] frame_handle;
      logic                   is_i_frame;
      logic [COUNT_BITS-1:0]  cut_count;
   } vfq_req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [HANDLE_BITS-1:0] out_handle;
      logic                   out_is_i_frame;
      logic [COUNT_BITS-1:0]  cut_i_now;
      logic [COUNT_BITS-1:0]  cut_p_now;
      logic [COUNT_BITS-1:0]  i_count;
      logic [COUNT_BITS-1:0]  p_count;
      logic                   over_i_limit;
      logic                   over_total_limit;
      logic [31:0]            dropped_i_total;
      logic [31:0]            dropped_p_total;
   } vfq_rsp_type;

endpackage

// ----- src/video_frame_queue_with_drop.sv -----
// Top level of the video frame queue with I-frame aware drop.
//
// Requests arrive on the req_ channel (valid/ready) and carry a function code:
// push, pop, clear, cut old or cut P. Every request yields exactly one response
// on the rsp_ channel (valid/ready) with the status, the popped frame, the
// frames removed, the counts held, the over-limit flags and the drop totals.
// The frame descriptors live in one RAM with a registered read.
// Push, clear and unknown codes go from acceptance straight to S_DONE, which
// registers the response; a pop that finds an entry passes S_POP first for
// the RAM read. Cut old and cut P walk every held entry, reading it in S_WRD,
// then deciding and writing it back in place in S_WPROC, and end in S_WEND
// and S_DONE; cut P with a zero count goes straight to S_DONE. One request
// is in flight at a time and req_ready returns with the registered response.
// The response sits in an output register; a new request is accepted while
// it waits, and a finished result is held until the receiver takes the
// previous one, so a stalled receiver stalls completion and acceptance. Reset
// clears the pointers, counts and totals at once and loads the limit registers
// with their defaults; the RAM needs no clearing pass. The user writes limit
// registers on the csr_ port only while the block is idle; not enforced here.
module video_frame_queue_with_drop #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  vfq_pkg::vfq_req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output vfq_pkg::vfq_rsp_type  rsp_data,
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_index,
   input  logic [6:0]            csr_wdata
);
   import vfq_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int MW = (CW > COUNT_BITS) ? CW : COUNT_BITS;
   localparam int TW = (CW + 1 > 2 * CFG_BITS) ? CW + 1 : 2 * CFG_BITS;

   typedef enum logic [2:0] {
      S_IDLE, S_POP, S_WRD, S_WPROC, S_WEND, S_DONE
   } state_type;

   state_type                  state_ff, state_in;
   logic [AW-1:0]              head_ff, head_in;
   logic [CW-1:0]              occ_ff, occ_in;
   logic [CW-1:0]              i_held_ff, i_held_in;
   logic [CW-1:0]              p_held_ff, p_held_in;
   logic [31:0]                i_sum_ff, i_sum_in;
   logic [31:0]                p_sum_ff, p_sum_in;
   logic [CFG_BITS-1:0]        i_limit_ff, i_limit_in;
   logic [CFG_BITS-1:0]        sec_limit_ff, sec_limit_in;
   logic [CFG_BITS-1:0]        fps_ff, fps_in;
   logic [2*CFG_BITS-1:0]      product_ff, product_in;
   logic [CW-1:0]              k_ff, k_in;
   logic [CW-1:0]              n_ff, n_in;
   logic [CW-1:0]              seen_ff, seen_in;
   logic [CW-1:0]              cut_i_ff, cut_i_in;
   logic [CW-1:0]              cut_p_ff, cut_p_in;
   logic                       stop_ff, stop_in;
   logic                       old_mode_ff, old_mode_in;
   logic [COUNT_BITS-1:0]      want_ff, want_in;
   logic [1:0]                 status_ff, status_in;
   logic [HANDLE_BITS-1:0]     oh_ff, oh_in;
   logic                       oi_ff, oi_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   vfq_rsp_type                rsp_data_ff, rsp_data_in;

   logic                       mem_we;
   logic [AW-1:0]              mem_waddr;
   logic [ENTRY_BITS-1:0]      mem_wdata;
   logic                       mem_re;
   logic [AW-1:0]              mem_raddr;
   logic [ENTRY_BITS-1:0]      mem_rdata;

   logic                       e_is_i;
   logic                       keep;
   logic [CW-1:0]              seen_next;

   function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [CW-1:0] b);
      logic [CW:0] s;
      s = (CW+1)'(a) + (CW+1)'(b);
      if (s >= (CW+1)'(QUEUE_DEPTH)) begin
         s = s - (CW+1)'(QUEUE_DEPTH);
      end
      return s[AW-1:0];
   endfunction

   vfq_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign e_is_i    = mem_rdata[HANDLE_BITS];
   assign seen_next = seen_ff + CW'(1);

   always_comb begin
      keep = 1'b1;
      if (!stop_ff) begin
         if (old_mode_ff) begin
            keep = e_is_i && (seen_next >= i_held_ff);
         end else begin
            keep = e_is_i;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      occ_in       = occ_ff;
      i_held_in    = i_held_ff;
      p_held_in    = p_held_ff;
      i_sum_in     = i_sum_ff;
      p_sum_in     = p_sum_ff;
      i_limit_in   = i_limit_ff;
      sec_limit_in = sec_limit_ff;
      fps_in       = fps_ff;
      product_in   = (2*CFG_BITS)'(sec_limit_ff) * (2*CFG_BITS)'(fps_ff);
      k_in         = k_ff;
      n_in         = n_ff;
      seen_in      = seen_ff;
      cut_i_in     = cut_i_ff;
      cut_p_in     = cut_p_ff;
      stop_in      = stop_ff;
      old_mode_in  = old_mode_ff;
      want_in      = want_ff;
      status_in    = status_ff;
      oh_in        = oh_ff;
      oi_in        = oi_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = '0;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_I_FRAME_LIMIT:     i_limit_in   = csr_wdata;
            CSR_SECONDS_LIMIT:     sec_limit_in = csr_wdata;
            CSR_FRAMES_PER_SECOND: fps_in       = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               status_in   = STATUS_OK;
               oh_in       = '0;
               oi_in       = 1'b0;
               cut_i_in    = '0;
               cut_p_in    = '0;
               k_in        = '0;
               n_in        = '0;
               seen_in     = '0;
               stop_in     = 1'b0;
               want_in     = req_data.cut_count;
               old_mode_in = (req_data.func == FUNC_CUT_OLD);
               state_in    = S_DONE;
               unique case (req_data.func)
                  FUNC_PUSH: begin
                     if (occ_ff >= CW'(QUEUE_DEPTH)) begin
                        status_in = STATUS_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = wrap_add(head_ff, occ_ff);
                        mem_wdata = {req_data.is_i_frame, req_data.frame_handle};
                        occ_in    = occ_ff + CW'(1);
                        if (req_data.is_i_frame) begin
                           i_held_in = i_held_ff + CW'(1);
                        end else begin
                           p_held_in = p_held_ff + CW'(1);
                        end
                     end
                  end
                  FUNC_POP: begin
                     if (occ_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = head_ff;
                        state_in  = S_POP;
                     end
                  end
                  FUNC_CLEAR: begin
                     cut_i_in  = i_held_ff;
                     cut_p_in  = p_held_ff;
                     head_in   = '0;
                     occ_in    = '0;
                     i_held_in = '0;
                     p_held_in = '0;
                  end
                  FUNC_CUT_OLD: state_in = S_WRD;
                  FUNC_CUT_P: begin
                     if (req_data.cut_count != '0) begin
                        state_in = S_WRD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_POP: begin
            oh_in = mem_rdata[HANDLE_BITS-1:0];
            oi_in = e_is_i;
            if (e_is_i) begin
               if (i_held_ff != '0) i_held_in = i_held_ff - CW'(1);
            end else begin
               if (p_held_ff != '0) p_held_in = p_held_ff - CW'(1);
            end
            head_in  = wrap_add(head_ff, CW'(1));
            occ_in   = occ_ff - CW'(1);
            state_in = S_DONE;
         end
         S_WRD: begin
            if (k_ff == occ_ff) begin
               state_in = S_WEND;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = wrap_add(head_ff, k_ff);
               state_in  = S_WPROC;
            end
         end
         S_WPROC: begin
            if (!stop_ff) begin
               if (e_is_i) begin
                  if (old_mode_ff) begin
                     seen_in = seen_next;
                     if (keep) begin
                        stop_in = 1'b1;
                     end else begin
                        cut_i_in = cut_i_ff + CW'(1);
                     end
                  end else if (MW'(cut_p_ff) >= MW'(want_ff)) begin
                     stop_in = 1'b1;
                  end
               end else begin
                  cut_p_in = cut_p_ff + CW'(1);
               end
            end
            if (keep) begin
               mem_we    = 1'b1;
               mem_waddr = wrap_add(head_ff, n_ff);
               mem_wdata = mem_rdata;
               n_in      = n_ff + CW'(1);
            end
            k_in     = k_ff + CW'(1);
            state_in = S_WRD;
         end
         S_WEND: begin
            occ_in    = n_ff;
            i_held_in = (cut_i_ff <= i_held_ff) ? i_held_ff - cut_i_ff : '0;
            p_held_in = (cut_p_ff <= p_held_ff) ? p_held_ff - cut_p_ff : '0;
            i_sum_in  = i_sum_ff + 32'(cut_i_ff);
            p_sum_in  = p_sum_ff + 32'(cut_p_ff);
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.status           = status_ff;
               rsp_data_in.out_handle       = oh_ff;
               rsp_data_in.out_is_i_frame   = oi_ff;
               rsp_data_in.cut_i_now        = COUNT_BITS'(cut_i_ff);
               rsp_data_in.cut_p_now        = COUNT_BITS'(cut_p_ff);
               rsp_data_in.i_count          = COUNT_BITS'(i_held_ff);
               rsp_data_in.p_count          = COUNT_BITS'(p_held_ff);
               rsp_data_in.over_i_limit     = MW'(i_held_ff) > MW'(i_limit_ff);
               rsp_data_in.over_total_limit =
                  (TW'(i_held_ff) + TW'(p_held_ff)) > TW'(product_ff);
               rsp_data_in.dropped_i_total  = i_sum_ff;
               rsp_data_in.dropped_p_total  = p_sum_ff;
               state_in                     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      product_ff  <= product_in;
      k_ff        <= k_in;
      n_ff        <= n_in;
      seen_ff     <= seen_in;
      cut_i_ff    <= cut_i_in;
      cut_p_ff    <= cut_p_in;
      stop_ff     <= stop_in;
      old_mode_ff <= old_mode_in;
      want_ff     <= want_in;
      status_ff   <= status_in;
      oh_ff       <= oh_in;
      oi_ff       <= oi_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         occ_ff       <= '0;
         i_held_ff    <= '0;
         p_held_ff    <= '0;
         i_sum_ff     <= '0;
         p_sum_ff     <= '0;
         i_limit_ff   <= CFG_BITS'(2);
         sec_limit_ff <= CFG_BITS'(1);
         fps_ff       <= CFG_BITS'(30);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         occ_ff       <= occ_in;
         i_held_ff    <= i_held_in;
         p_held_ff    <= p_held_in;
         i_sum_ff     <= i_sum_in;
         p_sum_ff     <= p_sum_in;
         i_limit_ff   <= i_limit_in;
         sec_limit_ff <= sec_limit_in;
         fps_ff       <= fps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The type counts always add up to the number of held entries.
   a_counts_match: assert property (@(posedge clock) disable iff (reset)
      (CW+1)'(i_held_ff) + (CW+1)'(p_held_ff) == (CW+1)'(occ_ff))
      else $error("frame type counts disagree with occupancy");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CW'(QUEUE_DEPTH))
      else $error("occupancy beyond queue depth");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is in flight");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WPROC) |-> (k_ff < occ_ff) && (n_ff <= k_ff))
      else $error("compaction pointers out of order");

endmodule

// ----- src/vfq_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module vfq_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- test/video_frame_queue_with_drop_test.sv -----
// Self-checking testbench of the video frame queue with I-frame aware drop.
`timescale 1ns / 100ps

module video_frame_queue_with_drop_test;
   import vfq_pkg::*;

   localparam int DEPTH = 64;

   typedef struct {
      logic [2:0]  func;
      logic [15:0] handle;
      logic        is_i;
      logic [6:0]  cut;
      bit          fixed;
      vfq_rsp_type rsp;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   vfq_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   vfq_rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [1:0] csr_index = '0;
   logic [6:0] csr_wdata = '0;

   video_frame_queue_with_drop dut (.*);

   always #5 clock = ~clock;

   // Shadow copy of the queue state and limit registers.
   logic [16:0] frames[$];
   logic [6:0] i_held, p_held;
   logic [31:0] i_drop_sum, p_drop_sum;
   logic [6:0] i_limit, sec_limit, fps;

   vfq_rsp_type rsp_queue[$];
   int errors = 0;
   int sent = 0;
   int received = 0;
   int cuts = 0;
   bit idle_on = 1'b1;
   bit in_quiet = 1'b0;

   function automatic vfq_rsp_type queue_step(vfq_req_type r);
      vfq_rsp_type o;
      logic [16:0] kept[$];
      int seen;
      o = '0;
      case (r.func)
         FUNC_PUSH: begin
            if (frames.size() >= DEPTH) begin
               o.status = STATUS_FULL;
            end else begin
               frames.insert(frames.size(), {r.is_i_frame, r.frame_handle});
               if (r.is_i_frame) i_held++; else p_held++;
            end
         end
         FUNC_POP: begin
            if (frames.size() == 0) begin
               o.status = STATUS_EMPTY;
            end else begin
               {o.out_is_i_frame, o.out_handle} = frames.pop_front();
               if (o.out_is_i_frame) i_held--; else p_held--;
            end
         end
         FUNC_CLEAR: begin
            o.cut_i_now = i_held;
            o.cut_p_now = p_held;
            frames.delete();
            i_held = 0;
            p_held = 0;
         end
         FUNC_CUT_OLD: begin
            seen = 0;
            foreach (frames[k]) begin
               if (frames[k][16]) begin
                  seen++;
                  if (seen >= i_held) begin
                     for (int j = k; j < frames.size(); j++) kept.insert(kept.size(), frames[j]);
                     break;
                  end
                  o.cut_i_now++;
               end else begin
                  o.cut_p_now++;
               end
            end
            frames = kept;
            i_held -= o.cut_i_now;
            p_held -= o.cut_p_now;
            i_drop_sum += o.cut_i_now;
            p_drop_sum += o.cut_p_now;
         end
         FUNC_CUT_P: begin
            if (r.cut_count != 0) begin
               foreach (frames[k]) begin
                  if (frames[k][16]) begin
                     if (o.cut_p_now >= r.cut_count) begin
                        for (int j = k; j < frames.size(); j++) kept.insert(kept.size(), frames[j]);
                        break;
                     end
                     kept.insert(kept.size(), frames[k]);
                  end else begin
                     o.cut_p_now++;
                  end
               end
               frames = kept;
               p_held -= o.cut_p_now;
               p_drop_sum += o.cut_p_now;
            end
         end
         default: ;
      endcase
      o.i_count = i_held;
      o.p_count = p_held;
      o.over_i_limit = i_held > i_limit;
      o.over_total_limit = (32'(i_held) + 32'(p_held)) > (32'(sec_limit) * 32'(fps));
      o.dropped_i_total = i_drop_sum;
      o.dropped_p_total = p_drop_sum;
      return o;
   endfunction

   task automatic send_request(vfq_req_type r);
      while (idle_on && !in_quiet && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      rsp_queue.insert(rsp_queue.size(), queue_step(r));
      sent++;
      if (r.func == FUNC_CUT_OLD || r.func == FUNC_CUT_P) cuts++;
      @(negedge clock);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      @(negedge clock);
      while (rsp_queue.size() != 0) @(negedge clock);
      repeat (2 * DEPTH + 10) @(negedge clock);
   endtask

   task automatic write_limits(logic [6:0] i_val, logic [6:0] s_val, logic [6:0] f_val);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_I_FRAME_LIMIT;
      csr_wdata <= i_val;
      @(negedge clock);
      csr_index <= CSR_SECONDS_LIMIT;
      csr_wdata <= s_val;
      @(negedge clock);
      csr_index <= CSR_FRAMES_PER_SECOND;
      csr_wdata <= f_val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      i_limit = i_val;
      sec_limit = s_val;
      fps = f_val;
   endtask

   always @(negedge clock) begin
      rsp_ready <= !(idle_on && !in_quiet && $urandom_range(99) < 14);
   end

   always @(posedge clock) begin
      vfq_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         received++;
         if (rsp_queue.size() == 0) begin
            $display("%0t: unexpected response, expected none actual %p", $realtime, rsp_data);
            errors++;
         end else begin
            want = rsp_queue.pop_front();
            if (rsp_data !== want) begin
               $display("%0t: mismatch expected %p actual %p", $realtime, want, rsp_data);
               errors++;
            end
         end
      end
   end

   function automatic vfq_req_type random_request(int mode);
      vfq_req_type r;
      int pick;
      r.frame_handle = 16'($urandom);
      r.is_i_frame = ($urandom_range(99) < 25);
      r.cut_count = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(6));
      pick = $urandom_range(99);
      if (pick < (mode == 1 ? 80 : 50)) r.func = FUNC_PUSH;
      else if (pick < 85) r.func = FUNC_POP;
      else if (pick < 88) r.func = FUNC_CLEAR;
      else if (pick < 93) r.func = FUNC_CUT_OLD;
      else if (pick < 98) r.func = FUNC_CUT_P;
      else r.func = 3'(5 + $urandom_range(2));
      return r;
   endfunction

   initial begin
      stim_row_type rows[$];
      stim_row_type row;
      vfq_req_type r;
      vfq_rsp_type got;

      i_limit = 7'd2; sec_limit = 7'd1; fps = 7'd30;
      i_held = 0; p_held = 0; i_drop_sum = 0; p_drop_sum = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Pop and cuts on an empty queue have fixed answers.
      row = '{FUNC_POP, 16'h0, 1'b0, 7'd0, 1'b1, '0};
      row.rsp.status = STATUS_EMPTY;
      rows.insert(rows.size(), row);
      row = '{FUNC_CUT_OLD, 16'h0, 1'b0, 7'd0, 1'b1, '0};
      rows.insert(rows.size(), row);
      row = '{FUNC_CUT_P, 16'h0, 1'b0, 7'd64, 1'b1, '0};
      rows.insert(rows.size(), row);
      rows.insert(rows.size(), '{FUNC_PUSH, 16'hFFFF, 1'b1, 7'h7F, 1'b0, '0});
      rows.insert(rows.size(), '{FUNC_PUSH, 16'h0000, 1'b0, 7'd0, 1'b0, '0});
      rows.insert(rows.size(), '{FUNC_PUSH, 16'hA5A5, 1'b1, 7'd0, 1'b0, '0});
      rows.insert(rows.size(), '{FUNC_PUSH, 16'h5A5A, 1'b0, 7'd0, 1'b0, '0});
      rows.insert(rows.size(), '{FUNC_PUSH, 16'h1234, 1'b0, 7'd0, 1'b0, '0});
      rows.insert(rows.size(), '{FUNC_PUSH, 16'h4321, 1'b1, 7'd0, 1'b0, '0});
      rows.insert(rows.size(), '{FUNC_POP, 16'h0, 1'b0, 7'd0, 1'b0, '0});
      rows.insert(rows.size(), '{3'd7, 16'hFFFF, 1'b1, 7'h7F, 1'b0, '0});
      rows.insert(rows.size(), '{3'd5, 16'h0, 1'b0, 7'd0, 1'b0, '0});
      rows.insert(rows.size(), '{FUNC_CUT_P, 16'h0, 1'b0, 7'd0, 1'b0, '0});
      rows.insert(rows.size(), '{FUNC_CUT_P, 16'h0, 1'b0, 7'd1, 1'b0, '0});
      rows.insert(rows.size(), '{FUNC_CUT_OLD, 16'h0, 1'b0, 7'd0, 1'b0, '0});
      rows.insert(rows.size(), '{FUNC_PUSH, 16'h0F0F, 1'b0, 7'd0, 1'b0, '0});
      rows.insert(rows.size(), '{FUNC_CLEAR, 16'h0, 1'b0, 7'd0, 1'b0, '0});
      rows.insert(rows.size(), '{FUNC_PUSH, 16'h00FF, 1'b0, 7'd0, 1'b0, '0});
      rows.insert(rows.size(), '{FUNC_CUT_OLD, 16'h0, 1'b0, 7'd0, 1'b0, '0});

      foreach (rows[k]) begin
         r = '{rows[k].func, rows[k].handle, rows[k].is_i, rows[k].cut};
         send_request(r);
         if (rows[k].fixed) begin
            got = rsp_queue[$];
            if (got !== rows[k].rsp) begin
               $display("%0t: table row %0d expected %p model %p", $realtime, k,
                        rows[k].rsp, got);
               errors++;
            end
         end
      end
      drain_responses();

      // Fill to the top and beyond under tight limits, cut P and cut old, then drain.
      write_limits(7'd0, 7'd0, 7'd1);
      for (int k = 0; k < DEPTH + 2; k++) begin
         r = '{FUNC_PUSH, 16'($urandom), 1'($urandom), 7'd0};
         send_request(r);
      end
      r = '{FUNC_CUT_P, 16'h0, 1'b0, 7'd64};
      send_request(r);
      r = '{FUNC_CUT_OLD, 16'h0, 1'b0, 7'd0};
      send_request(r);
      drain_responses();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               write_limits(7'd64, 7'd64, 7'd120);
            end
            1: begin
               write_limits(7'h7F, 7'h7F, 7'h7F);
               in_quiet = 1'b1;
            end
            default: begin
               in_quiet = 1'b0;
               write_limits(7'($urandom_range(10)), 7'($urandom_range(3)),
                            7'($urandom_range(1, 20)));
            end
         endcase
         for (int k = 0; k < 215; k++) begin
            send_request(random_request(phase % 2));
            if (phase == 2 && k == 100) begin
               req_valid <= 1'b0;
               @(negedge clock);
               while (rsp_queue.size() != 0) @(negedge clock);
            end
         end
         drain_responses();
      end

      $display("Sent %0d requests (%0d cuts), checked %0d responses.", sent, cuts, received);
      if (errors == 0 && rsp_queue.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
